// ===== src/hcbp_pkg.sv =====
`default_nettype none
package hcbp_pkg;

	localparam int SymbolCount = 256;
	localparam int MaxCodeBits = 32;
	localparam int SymW = 8;
	localparam int CodeW = 32;
	localparam int LenW = 6;
	localparam int AddrW = $clog2(SymbolCount);
	localparam int MaxBytes = 4;

	typedef logic [1:0] op_t;
	localparam op_t OpLoad = 2'd0;
	localparam op_t OpEncode = 2'd1;
	localparam op_t OpFlush = 2'd2;

	typedef struct packed {
		logic [LenW-1:0] len;
		logic [CodeW-1:0] code;
	} entry_t;

endpackage
`default_nettype wire

// ===== src/hcbp_cmd_if.sv =====
`default_nettype none
interface hcbp_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [7:0] symbol;
	logic [31:0] code_word;
	logic [5:0] code_length;

	modport source (output valid, operation, symbol, code_word, code_length, input ready);
	modport sink (input valid, operation, symbol, code_word, code_length, output ready);
endinterface
`default_nettype wire

// ===== src/hcbp_byte_if.sv =====
`default_nettype none
interface hcbp_byte_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== src/huffman_code_bit_packer_top.sv =====
`default_nettype none
// channel  dir  payload                                       role
// cmd      in   operation, symbol, code_word, code_length     load, encode, flush requests
// stream   out  out_byte, last                                packed bytes, last per request
//
// one request per cycle while cmd.ready is high; after a registered table read, the
// packer stage turns the code into zero to four bytes, which drain one per cycle
// while stream.ready is high; a request waiting behind them holds the input
// until the last byte is taken; arst_n clears the pipeline, the byte count and
// the partial byte; the code table has no reset and must be loaded before use
// a stall on stream backs up through the packer stage to cmd.ready
module huffman_code_bit_packer_top (
	input wire logic clk,
	input wire logic arst_n,
	hcbp_cmd_if.sink cmd,
	hcbp_byte_if.source stream
);
	import hcbp_pkg::*;

	hcbp_pkg::entry_t mem [SymbolCount];

	logic accept;
	logic advance;
	logic s2_free;

	logic valid_s1;
	op_t op_s1;
	logic in_range_s1;
	entry_t rd_s1;

	logic [7:0] partial_q;
	logic [2:0] filled_q;

	logic [31:0] buf_q;
	logic [2:0] cnt_q;

	logic [LenW-1:0] len_c;
	logic [CodeW-1:0] code_c;
	logic [39:0] win_c;
	logic [39:0] rest_c;
	logic [LenW:0] total_c;
	logic [2:0] nbytes_c;
	logic enc_c;
	logic flush_c;

	assign s2_free = (cnt_q == 3'd0) || (cnt_q == 3'd1 && stream.ready);
	assign advance = !valid_s1 || s2_free;
	assign cmd.ready = advance;
	assign accept = cmd.valid && cmd.ready;

	always_ff @(posedge clk) begin
		if (accept && cmd.operation == OpLoad
				&& {1'b0, cmd.symbol} < 9'(SymbolCount)) begin
			mem[cmd.symbol[AddrW-1:0]] <= '{len: cmd.code_length, code: cmd.code_word};
		end
		if (accept) begin
			rd_s1 <= mem[cmd.symbol[AddrW-1:0]];
			op_s1 <= cmd.operation;
			in_range_s1 <= {1'b0, cmd.symbol} < 9'(SymbolCount);
		end
	end

	always_comb begin
		len_c = (rd_s1.len > LenW'(MaxCodeBits)) ? LenW'(MaxCodeBits) : rd_s1.len;
		code_c = rd_s1.code & ~(32'hFFFF_FFFF >> len_c);
		win_c = {partial_q, 32'd0} | ({code_c, 8'd0} >> filled_q);
		total_c = {4'd0, filled_q} + {1'b0, len_c};
		nbytes_c = total_c[5:3];
		rest_c = win_c << {nbytes_c, 3'b000};
		enc_c = valid_s1 && op_s1 == OpEncode && in_range_s1;
		flush_c = valid_s1 && op_s1 == OpFlush && filled_q != 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			partial_q <= '0;
			filled_q <= '0;
			cnt_q <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= accept;
			end
			if (valid_s1 && advance) begin
				unique case (1'b1)
					enc_c: begin
						partial_q <= rest_c[39:32];
						filled_q <= total_c[2:0];
						cnt_q <= nbytes_c;
					end
					flush_c: begin
						partial_q <= '0;
						filled_q <= '0;
						cnt_q <= 3'd1;
					end
					default: cnt_q <= '0;
				endcase
			end else if (stream.valid && stream.ready) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			buf_q <= flush_c ? {partial_q, 24'd0} : win_c[39:8];
		end else if (stream.valid && stream.ready) begin
			buf_q <= {buf_q[23:0], 8'd0};
		end
	end

	assign stream.valid = cnt_q != 3'd0;
	assign stream.out_byte = buf_q[31:24];
	assign stream.last = cnt_q == 3'd1;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MaxBytes))
		else $error("byte count above four");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && cnt_q != 3'd0)
		else $error("input stalled with nothing pending");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && op_s1 == OpFlush |=> filled_q == 3'd0 && partial_q == 8'd0)
		else $error("flush left bits behind");

	a_partial_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q == 3'd0 |-> partial_q == 8'd0)
		else $error("empty partial byte holds bits");
`endif

endmodule
`default_nettype wire

// ===== bench/huffman_code_bit_packer_top_test.sv =====
module huffman_code_bit_packer_top_test;
	import hcbp_pkg::*;

	localparam op_t OpUnused = 2'd3;
	localparam int HoldCycles = 300;
	localparam int RandomRequests = 300;

	typedef struct {
		op_t op;
		logic [7:0] symbol;
		logic [31:0] code_word;
		logic [5:0] code_length;
		bit drain;
	} cmd_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} packed_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	op_t req_op = OpLoad;
	logic [7:0] req_symbol = '0;
	logic [31:0] req_code = '0;
	logic [5:0] req_len = '0;
	logic byte_ready = 1'b0;
	logic hold_off = 1'b0;

	hcbp_cmd_if cmd_ch();
	hcbp_byte_if byte_ch();

	assign cmd_ch.valid = req_valid;
	assign cmd_ch.operation = req_op;
	assign cmd_ch.symbol = req_symbol;
	assign cmd_ch.code_word = req_code;
	assign cmd_ch.code_length = req_len;
	assign byte_ch.ready = byte_ready;

	huffman_code_bit_packer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.stream(byte_ch)
	);

	always #5 clk = ~clk;

	cmd_req_t pending[$];
	packed_byte_t expected_bytes[$];
	bit loaded[SymbolCount];
	logic [7:0] loaded_syms[$];

	// packer state as the block should hold it
	bit [31:0] code_words[SymbolCount];
	bit [5:0] code_lens[SymbolCount];
	bit [7:0] partial_bits = '0;
	bit [2:0] bits_held = '0;

	int sent_count = 0;
	int total_requests = 0;
	int mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm = $urandom_range(20, 60);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [5:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 6'($urandom_range(1, 8));
		if (r < 90)
			return 6'($urandom_range(9, MaxCodeBits));
		if (r < 95)
			return 6'd0;
		return 6'($urandom_range(MaxCodeBits + 1, 63));
	endfunction

	task automatic pack_request(input cmd_req_t r);
		bit [31:0] code;
		bit [63:0] window;
		int len;
		int total;
		int nbytes;
		packed_byte_t b;
		case (r.op)
			OpLoad: begin
				code_words[r.symbol] = r.code_word;
				code_lens[r.symbol] = r.code_length;
			end
			OpEncode: begin
				len = code_lens[r.symbol];
				if (len > MaxCodeBits)
					len = MaxCodeBits;
				if (len != 0) begin
					code = code_words[r.symbol];
					if (len < 32)
						code &= ~(32'hFFFF_FFFF >> len);
					window = {partial_bits, 56'd0} | ({code, 32'd0} >> bits_held);
					total = bits_held + len;
					nbytes = total / 8;
					if (nbytes > MaxBytes)
						nbytes = MaxBytes;
					for (int i = 0; i < nbytes; i++) begin
						b.data = window[63:56];
						b.last = (i == nbytes - 1);
						expected_bytes.push_back(b);
						window <<= 8;
					end
					partial_bits = window[63:56];
					bits_held = 3'(total - 8 * nbytes);
				end
			end
			OpFlush: begin
				if (bits_held != 0) begin
					b.data = partial_bits;
					b.last = 1'b1;
					expected_bytes.push_back(b);
					partial_bits = '0;
					bits_held = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	// request driver
	int send_gap = 0;
	int send_calm = 0;
	cmd_req_t cur_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && cmd_ch.ready) begin
				pack_request(cur_req);
				sent_count++;
			end
			if (!req_valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap--;
				end else if (pending.size() > 0 &&
						(!pending[0].drain || expected_bytes.size() == 0)) begin
					cur_req = pending.pop_front();
					req_op <= cur_req.op;
					req_symbol <= cur_req.symbol;
					req_code <= cur_req.code_word;
					req_len <= cur_req.code_length;
					req_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// byte monitor
	int recv_gap = 0;
	int recv_calm = 0;
	packed_byte_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ready <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h last %0b with nothing expected",
						byte_ch.out_byte, byte_ch.last));
				end else begin
					want = expected_bytes.pop_front();
					if (byte_ch.out_byte !== want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							byte_ch.out_byte, want.data));
					if (byte_ch.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
							byte_ch.last, want.last, want.data));
				end
			end
			if (hold_off) begin
				byte_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				byte_ready <= 1'b0;
				recv_gap--;
			end else begin
				byte_ready <= 1'b1;
				recv_gap = pick_gap(recv_calm);
			end
		end
	end

	// long receiver stall so the block backs up into the request side
	initial begin
		wait (sent_count >= 120);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic push_req(input op_t op, input logic [7:0] sym, input logic [31:0] code,
			input logic [5:0] len, input bit drain = 1'b0);
		cmd_req_t r;
		r.op = op;
		r.symbol = sym;
		r.code_word = code;
		r.code_length = len;
		r.drain = drain;
		pending.push_back(r);
		if (op == OpLoad && !loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	initial begin
		int counted;
		int r;
		logic [7:0] sym;

		// directed part
		push_req(OpLoad, 8'd0, 32'hFFFF_FFFF, 6'd32);
		push_req(OpLoad, 8'd255, 32'h8000_0000, 6'd1);
		push_req(OpLoad, 8'd1, 32'hA5A5_A5A5, 6'd0);
		push_req(OpLoad, 8'd2, 32'h5555_5555, 6'd63);
		push_req(OpLoad, 8'd3, 32'hFFFF_FFFF, 6'd3);
		push_req(OpLoad, 8'd4, 32'h0000_0000, 6'd8);
		push_req(OpFlush, 8'd0, 32'd0, 6'd0);
		push_req(OpUnused, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		push_req(OpEncode, 8'd255, 32'd0, 6'd0);
		push_req(OpEncode, 8'd0, 32'd0, 6'd0);
		push_req(OpEncode, 8'd1, 32'd0, 6'd0);
		push_req(OpEncode, 8'd2, 32'd0, 6'd0);
		push_req(OpEncode, 8'd3, 32'd0, 6'd0);
		push_req(OpFlush, 8'd0, 32'd0, 6'd0);
		push_req(OpFlush, 8'd0, 32'd0, 6'd0);
		push_req(OpEncode, 8'd4, 32'd0, 6'd0);
		push_req(OpEncode, 8'd2, 32'd0, 6'd0, 1'b1);
		push_req(OpLoad, 8'h40, 32'hFE00_0001, 6'd7);
		for (int i = 0; i < 7; i++)
			push_req(OpEncode, 8'h40, 32'd0, 6'd0);
		push_req(OpFlush, 8'd0, 32'd0, 6'd0);

		// random part, mostly short codes; loads favour symbols 0 to 15
		counted = 0;
		while (counted < RandomRequests) begin
			r = $urandom_range(0, 99);
			if (loaded_syms.size() < 4 || r < 12) begin
				sym = (r < 6) ? 8'($urandom_range(0, 15)) : 8'($urandom);
				push_req(OpLoad, sym, $urandom, pick_length());
				counted++;
			end else if (r < 82) begin
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				push_req(OpEncode, sym, $urandom, 6'($urandom), $urandom_range(0, 49) == 0);
				counted++;
			end else if (r < 95) begin
				push_req(OpFlush, 8'($urandom), $urandom, 6'($urandom));
				counted++;
			end else begin
				push_req(OpUnused, 8'($urandom), $urandom, 6'($urandom));
			end
		end
		total_requests = pending.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (sent_count == total_requests);
		wait (expected_bytes.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
